@@ rtl/sha1s_pkg.sv @@
// Shared types and constants of the SHA-1 stream hasher.
package sha1s_pkg;

    typedef logic [1:0]  t_cmd;
    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    localparam t_cmd CMD_INIT   = 2'd0;
    localparam t_cmd CMD_ABSORB = 2'd1;
    localparam t_cmd CMD_FINISH = 2'd2;

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam t_word IV_0 = 32'h67452301;
    localparam t_word IV_1 = 32'hEFCDAB89;
    localparam t_word IV_2 = 32'h98BADCFE;
    localparam t_word IV_3 = 32'h10325476;
    localparam t_word IV_4 = 32'hC3D2E1F0;

    localparam logic [7:0] MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

@@ rtl/sha1s_if.sv @@
// Handshake channels of the SHA-1 stream hasher: command beats in, digest beats out.
interface sha1s_cmd_if;
    import sha1s_pkg::*;
    logic       valid;
    logic       ready;
    t_cmd       command;
    logic [7:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha1s_dig_if;
    import sha1s_pkg::*;
    logic       valid;
    logic       ready;
    t_word      digest_word;
    logic [2:0] word_index;
    logic       last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sha1s_round.sv @@
// Shared SHA-1 round unit: one compression round and one message schedule step.
module sha1s_round (
    input  sha1s_pkg::t_work i_work,
    input  logic [6:0]       i_round,
    input  sha1s_pkg::t_word i_w0,
    input  sha1s_pkg::t_word i_w2,
    input  sha1s_pkg::t_word i_w8,
    input  sha1s_pkg::t_word i_w13,
    output sha1s_pkg::t_work o_work,
    output sha1s_pkg::t_word o_wnext
);
    import sha1s_pkg::*;

    t_word w_mix;
    t_word w_cur;
    t_word f_val;
    t_word k_val;
    t_word t_sum;

    // The first sixteen rounds recirculate the loaded words; later ones expand.
    assign w_mix = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
    assign w_cur = (i_round < 7'd16) ? i_w0 : {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (i_round < 7'd20) begin
            f_val = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k_val = K_0;
        end else if (i_round < 7'd40) begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = K_1;
        end else if (i_round < 7'd60) begin
            f_val = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k_val = K_2;
        end else begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = K_3;
        end
    end

    assign t_sum = {i_work.a[26:0], i_work.a[31:27]} + f_val + i_work.e + k_val + w_cur;

    assign o_work.a = t_sum;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;
    assign o_wnext  = w_cur;

endmodule

@@ rtl/sha1_stream_hasher_core.sv @@
// SHA-1 stream hasher: byte absorber, padding sequencer and iterative compression.
//
// Usage: command beats arrive on i_cmd (init, absorb with data_byte, finish).
// An init or absorb is taken whenever the block is idle; the absorb that fills the
// 64th byte of a block starts a compression: 80 rounds through the
// single shared round unit, one per cycle, then a fold step that adds the result
// into the chaining words. i_cmd.ready is low during that time.
// Finish pushes the padding and length bytes one per cycle through the same
// byte path, pausing while each block that fills is compressed, then offers
// the five digest words on o_dig, word 0 first, the fifth with last_word set.
// The block takes no command until the fifth word beat is taken; a stalled
// receiver simply holds the block in that phase with the current word on the
// port. For long messages, each 64 absorbed bytes are followed by the
// compression loop, during which no further byte is taken.
// Reset (synchronous, active low) loads the initial chaining words and clears
// the bit count and fill position, which is the same as an init command.
module sha1_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1s_cmd_if.sink   i_cmd,
    sha1s_dig_if.source o_dig
);
    import sha1s_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PD_NONE,
        PD_MARK,
        PD_ZERO,
        PD_LEN,
        PD_DONE
    } t_pad;

    t_state       r_state, n_state;
    t_pad         r_pad, n_pad;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_bits, n_bits;
    logic [63:0]  r_len, n_len;
    logic [2:0]   r_len_cnt, n_len_cnt;
    logic [2:0]   r_widx, n_widx;
    logic [6:0]   r_round, n_round;
    logic [511:0] r_buf, n_buf;
    t_word        r_chain [5];
    t_word        n_chain [5];
    t_work        r_work, n_work;

    logic         push_en;
    logic [7:0]   push_byte;
    t_work        rnd_work;
    t_word        rnd_w;
    t_work        chain_work;

    assign chain_work = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                          d: r_chain[3], e: r_chain[4]};

    // The block buffer is a shift line: slot 0 is the oldest word.
    sha1s_round u_round (
        .i_work  (r_work),
        .i_round (r_round),
        .i_w0    (r_buf[511:480]),
        .i_w2    (r_buf[447:416]),
        .i_w8    (r_buf[255:224]),
        .i_w13   (r_buf[95:64]),
        .o_work  (rnd_work),
        .o_wnext (rnd_w)
    );

    assign i_cmd.ready       = (r_state == ST_IDLE);
    assign o_dig.valid       = (r_state == ST_OUT);
    assign o_dig.digest_word = r_chain[r_widx];
    assign o_dig.word_index  = r_widx;
    assign o_dig.last_word   = (r_widx == LAST_WORD_IDX);

    always_comb begin
        n_state   = r_state;
        n_pad     = r_pad;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_len     = r_len;
        n_len_cnt = r_len_cnt;
        n_widx    = r_widx;
        n_round   = r_round;
        n_buf     = r_buf;
        n_chain   = r_chain;
        n_work    = r_work;
        push_en   = 1'b0;
        push_byte = 8'd0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.command)
                        CMD_INIT: begin
                            n_chain = '{IV_0, IV_1, IV_2, IV_3, IV_4};
                            n_bits  = 64'd0;
                            n_fill  = 6'd0;
                        end
                        CMD_ABSORB: begin
                            n_bits    = r_bits + 64'd8;
                            push_en   = 1'b1;
                            push_byte = i_cmd.data_byte;
                        end
                        CMD_FINISH: begin
                            n_len   = r_bits;
                            n_pad   = PD_MARK;
                            n_state = ST_PAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                case (r_pad)
                    PD_MARK: begin
                        push_byte = MARK_BYTE;
                        n_pad     = PD_ZERO;
                    end
                    PD_ZERO: begin
                        if (r_fill == LEN_POS) begin
                            push_byte = r_len[63:56];
                            n_len     = {r_len[55:0], 8'd0};
                            n_len_cnt = 3'd1;
                            n_pad     = PD_LEN;
                        end else begin
                            push_byte = 8'd0;
                        end
                    end
                    PD_LEN: begin
                        push_byte = r_len[63:56];
                        n_len     = {r_len[55:0], 8'd0};
                        n_len_cnt = r_len_cnt + 3'd1;
                        if (r_len_cnt == 3'd7) begin
                            n_pad = PD_DONE;
                        end
                    end
                    default: push_en = 1'b0;
                endcase
            end
            ST_ROUND: begin
                n_work  = rnd_work;
                n_buf   = {r_buf[479:0], rnd_w};
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_chain[0] = r_chain[0] + r_work.a;
                n_chain[1] = r_chain[1] + r_work.b;
                n_chain[2] = r_chain[2] + r_work.c;
                n_chain[3] = r_chain[3] + r_work.d;
                n_chain[4] = r_chain[4] + r_work.e;
                if (r_pad == PD_DONE) begin
                    n_state = ST_OUT;
                    n_widx  = 3'd0;
                    // The length field counts toward the bit count; padding does not.
                    n_bits  = r_bits + 64'd64;
                end else if (r_pad == PD_NONE) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (o_dig.ready) begin
                    if (r_widx == LAST_WORD_IDX) begin
                        n_state = ST_IDLE;
                        n_pad   = PD_NONE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // A byte that completes the block hands off to the round loop.
        if (push_en) begin
            n_buf  = {r_buf[503:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == LAST_POS) begin
                n_state = ST_ROUND;
                n_round = 7'd0;
                n_work  = chain_work;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pad     <= PD_NONE;
            r_fill    <= 6'd0;
            r_bits    <= 64'd0;
            r_len_cnt <= 3'd0;
            r_widx    <= 3'd0;
            r_round   <= 7'd0;
            r_chain   <= '{IV_0, IV_1, IV_2, IV_3, IV_4};
        end else begin
            r_state   <= n_state;
            r_pad     <= n_pad;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_len_cnt <= n_len_cnt;
            r_widx    <= n_widx;
            r_round   <= n_round;
            r_chain   <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_work <= n_work;
        r_len  <= n_len;
    end

endmodule

@@ rtl/sha1s_checker.sv @@
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
module sha1s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    // Commands are never taken while digest beats are pending.
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("command channel ready while digest is being emitted");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd4)) && (i_out_index <= 3'd4))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && (i_out_index == $past(i_out_index) + 3'd1)))
        else $error("digest words not emitted in sequence");

    a_end_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("block did not return to idle after the final digest beat");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_out_index)))
        else $error("stalled digest beat changed");

endmodule

bind sha1_stream_hasher_core sha1s_checker u_sha1s_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_word  (o_dig.digest_word),
    .i_out_index (o_dig.word_index),
    .i_out_last  (o_dig.last_word)
);
